// File: design/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg: shared types and constants of the GPS track heading estimator
// Field widths, state encodings, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package gte_pkg;

  localparam int EastW  = 30;
  localparam int NorthW = 34;
  localparam int ZoneW  = 11;
  localparam int TagW   = 32;
  localparam int ThrW   = 40;
  localparam int OutW   = 16;

  localparam int CordicSteps = 20;
  localparam int StepW       = 5;

  localparam logic [21:0] PiQ20      = 22'd3294199;
  localparam logic [21:0] HalfPiQ20  = 22'd1647099;
  localparam logic [29:0] GainInvQ30 = 30'd652032874;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIFF, S_SQ, S_CMP, S_START, S_WAIT, S_PUSH
  } state_t;

  typedef enum logic [2:0] {
    H_IDLE, H_NORM, H_VEC, H_MAG, H_ROT, H_DONE
  } hstate_t;

  typedef struct packed {
    logic start;
    logic ack;
  } hd_ctrl_t;

  typedef struct packed {
    logic done;
  } hd_stat_t;

  // atan(2^-i) in Q.20 radians
  function automatic logic [19:0] atan_q20(input logic [StepW-1:0] i);
    logic [19:0] v;
    case (i)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/gte_fix_if.sv
// ----------------------------------------------------------------------------
// gte_fix_if: input channel of the heading estimator
// One GPS fix in UTM form with its tag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gte_fix_if;
  logic                            valid;
  logic                            ready;
  logic [gte_pkg::EastW-1:0]       easting_mm;
  logic [gte_pkg::NorthW-1:0]      northing_mm;
  logic [5:0]                      zone_number;
  logic [4:0]                      zone_band;
  logic [gte_pkg::TagW-1:0]        fix_tag;

  modport source(output valid, easting_mm, northing_mm, zone_number, zone_band, fix_tag,
                 input ready);
  modport sink(input valid, easting_mm, northing_mm, zone_number, zone_band, fix_tag,
               output ready);
endinterface

// File: design/gte_head_if.sv
// ----------------------------------------------------------------------------
// gte_head_if: result channel of the heading estimator
// Heading, yaw quaternion terms and tag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gte_head_if;
  logic                               valid;
  logic                               ready;
  logic signed [gte_pkg::OutW-1:0]    yaw_angle;
  logic signed [gte_pkg::OutW-1:0]    quat_z;
  logic signed [gte_pkg::OutW-1:0]    quat_w;
  logic [gte_pkg::TagW-1:0]           result_tag;

  modport source(output valid, yaw_angle, quat_z, quat_w, result_tag, input ready);
  modport sink(input valid, yaw_angle, quat_z, quat_w, result_tag, output ready);
endinterface

// File: design/gte_heading_cordic.sv
// ----------------------------------------------------------------------------
// gte_heading_cordic: iterative heading and half-angle sine/cosine unit
// Normalizes one bit a cycle, then one vectoring and one rotation step a cycle.
// ----------------------------------------------------------------------------
module gte_heading_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  gte_pkg::hd_ctrl_t            ctrl,
  input  logic signed [30:0]           de,
  input  logic signed [34:0]           dn,
  output gte_pkg::hd_stat_t            stat,
  output logic signed [15:0]           yaw_angle,
  output logic signed [15:0]           quat_z,
  output logic signed [15:0]           quat_w
);
  import gte_pkg::*;

  hstate_t             hstate, hstate_next;
  logic [40:0]         ax, ay;
  logic                neg_n, neg_e;
  logic [StepW-1:0]    step;
  logic signed [44:0]  vx, vy;
  logic signed [22:0]  acc;
  logic signed [32:0]  rx, ry;
  logic signed [22:0]  h;
  logic signed [15:0]  yaw;

  logic signed [44:0]  vxs, vys;
  logic signed [32:0]  rxs, rys;
  logic signed [22:0]  atan_s;
  logic [21:0]         a_cl, mag;
  logic [22:0]         ym_sum;
  logic [14:0]         s_q, c_q;
  logic                last_step;

  function automatic logic [14:0] round_q14(input logic signed [32:0] v);
    logic [30:0] c;
    logic [30:0] sum;
    if (v < 0) begin
      c = '0;
    end else if (v > 33'sd1073741824) begin
      c = 31'd1073741824;
    end else begin
      c = v[30:0];
    end
    sum = c + 31'd32768;
    return sum[30:16];
  endfunction

  assign vxs       = vx >>> step;
  assign vys       = vy >>> step;
  assign rxs       = rx >>> step;
  assign rys       = ry >>> step;
  assign atan_s    = $signed({3'b000, atan_q20(step)});
  assign last_step = (step == StepW'(CordicSteps - 1));

  // clamp the first-quadrant angle, then fold into [0, pi]
  always_comb begin
    if (acc < 0) begin
      a_cl = '0;
    end else if (acc > $signed({1'b0, HalfPiQ20})) begin
      a_cl = HalfPiQ20;
    end else begin
      a_cl = acc[21:0];
    end
    mag    = neg_e ? (PiQ20 - a_cl) : a_cl;
    ym_sum = {1'b0, mag} + 23'd64;
  end

  assign s_q       = round_q14(ry);
  assign c_q       = round_q14(rx);
  assign yaw_angle = yaw;
  assign quat_z    = neg_n ? -$signed({1'b0, s_q}) : $signed({1'b0, s_q});
  assign quat_w    = $signed({1'b0, c_q});

  always_comb begin
    hstate_next = hstate;
    case (hstate)
      H_IDLE: begin
        if (ctrl.start) hstate_next = H_NORM;
      end
      H_NORM: begin
        if (ay == '0 || ax == '0) begin
          hstate_next = H_MAG;
        end else if (!ax[40] && !ay[40]) begin
          hstate_next = H_NORM;
        end else begin
          hstate_next = H_VEC;
        end
      end
      H_VEC: begin
        if (last_step) hstate_next = H_MAG;
      end
      H_MAG: hstate_next = H_ROT;
      H_ROT: begin
        if (last_step) hstate_next = H_DONE;
      end
      H_DONE: begin
        if (ctrl.ack) hstate_next = H_IDLE;
      end
      default: hstate_next = H_IDLE;
    endcase
  end

  always_comb begin
    stat.done = (hstate == H_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
    end else begin
      hstate <= hstate_next;
    end
  end

  always_ff @(posedge clk) begin
    case (hstate)
      H_IDLE: begin
        ax    <= {10'd0, (de[30] ? 31'(-de) : 31'(de))};
        ay    <= {6'd0, (dn[34] ? 35'(-dn) : 35'(dn))};
        neg_e <= de[30];
        neg_n <= dn[34];
      end
      H_NORM: begin
        if (ay == '0) begin
          acc <= '0;
        end else if (ax == '0) begin
          acc <= $signed({1'b0, HalfPiQ20});
        end else if (!ax[40] && !ay[40]) begin
          ax <= {ax[39:0], 1'b0};
          ay <= {ay[39:0], 1'b0};
        end else begin
          vx   <= $signed({4'd0, ax});
          vy   <= $signed({4'd0, ay});
          acc  <= '0;
          step <= '0;
        end
      end
      H_VEC: begin
        if (!vy[44]) begin
          vx  <= vx + vys;
          vy  <= vy - vxs;
          acc <= acc + atan_s;
        end else begin
          vx  <= vx - vys;
          vy  <= vy + vxs;
          acc <= acc - atan_s;
        end
        step <= last_step ? '0 : step + StepW'(1);
      end
      H_MAG: begin
        yaw  <= neg_n ? -$signed({1'b0, ym_sum[21:7]}) : $signed({1'b0, ym_sum[21:7]});
        h    <= $signed({2'b00, mag[21:1]});
        rx   <= $signed({3'b000, GainInvQ30});
        ry   <= '0;
        step <= '0;
      end
      H_ROT: begin
        if (!h[22]) begin
          rx <= rx - rys;
          ry <= ry + rxs;
          h  <= h - atan_s;
        end else begin
          rx <= rx + rys;
          ry <= ry - rxs;
          h  <= h + atan_s;
        end
        step <= last_step ? '0 : step + StepW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/gps_track_heading_estimator_unit.sv
// ----------------------------------------------------------------------------
// gps_track_heading_estimator_unit: course-over-ground heading from UTM fixes
// History search, match threshold and CORDIC heading with yaw quaternion.
// ----------------------------------------------------------------------------
// Each accepted fix is compared against the stored history, newest first, one
// entry at a time (memory read, difference, square, compare). The first entry
// in the same zone and band whose squared distance reaches the threshold
// register (or whose offset on either axis is 2^20 mm or more) matches: the
// heading from that fix to the new one is produced as Q3.13 yaw with the Q1.14
// sin/cos of half the yaw, and older history is dropped. The new fix is then
// written as newest, the oldest entry going when the store is full. A match
// adds the CORDIC and handoff (one normalize bit, vectoring step or rotation
// step per cycle), and a fix takes longer while an earlier result still waits
// at the output; a full search of HISTORY_DEPTH entries sets the worst case.
// A new fix is taken only once the last is through. The history memory needs
// no clearing pass. The user writes the threshold through cfg_we/cfg_wdata
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gps_track_heading_estimator_unit #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [gte_pkg::ThrW-1:0]   cfg_wdata,
  gte_fix_if.sink                    fix,
  gte_head_if.source                 head
);
  import gte_pkg::*;

  localparam int AddrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int WordW = ZoneW + NorthW + EastW;

  // history memory: {grid zone, northing, easting}
  logic [WordW-1:0]   mem [HISTORY_DEPTH];
  logic [WordW-1:0]   rd_data;

  state_t             state, state_next;
  logic [ThrW-1:0]    thr;
  logic [AddrW-1:0]   newest, newest_next;
  logic [CntW-1:0]    count, count_cap;
  logic [CntW-1:0]    k, k_inc;
  logic [AddrW-1:0]   slot;

  // request held while searching
  logic [EastW-1:0]   f_e;
  logic [NorthW-1:0]  f_n;
  logic [ZoneW-1:0]   f_gz;
  logic [TagW-1:0]    f_tag;

  logic signed [30:0] de_r;
  logic signed [34:0] dn_r;
  logic [30:0]        ue;
  logic [34:0]        un;
  logic               zm;
  logic               big;
  logic [39:0]        sq_e, sq_n;
  logic [40:0]        d2;
  logic               match;

  logic               ov;
  logic               out_free;
  logic               out_load;

  hd_ctrl_t           hctrl;
  hd_stat_t           hstat;
  logic signed [15:0] c_yaw, c_qz, c_qw;

  gte_heading_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (hctrl),
    .de        (de_r),
    .dn        (dn_r),
    .stat      (hstat),
    .yaw_angle (c_yaw),
    .quat_z    (c_qz),
    .quat_w    (c_qw)
  );

  assign k_inc    = k + CntW'(1);
  assign d2       = {1'b0, sq_e} + {1'b0, sq_n};
  assign match    = zm && (big || (d2 >= {1'b0, thr}));
  assign out_free = !ov || head.ready;
  assign head.valid = ov;

  // magnitudes of the held differences
  assign ue = de_r[30] ? 31'(-de_r) : 31'(de_r);
  assign un = dn_r[34] ? 35'(-dn_r) : 35'(dn_r);

  // drop the oldest entry when full, then make room for the new fix
  assign count_cap   = (count >= CntW'(HISTORY_DEPTH)) ? CntW'(HISTORY_DEPTH - 1) : count;
  assign newest_next = (newest == AddrW'(HISTORY_DEPTH - 1)) ? '0 : newest + AddrW'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (fix.valid) state_next = (count == '0) ? S_PUSH : S_READ;
      end
      S_READ:  state_next = S_DIFF;
      S_DIFF:  state_next = S_SQ;
      S_SQ:    state_next = S_CMP;
      S_CMP: begin
        if (match) begin
          state_next = S_START;
        end else if (k_inc == count) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_READ;
        end
      end
      S_START: state_next = S_WAIT;
      S_WAIT: begin
        if (hstat.done && out_free) state_next = S_PUSH;
      end
      S_PUSH:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and unit control
  always_comb begin
    fix.ready   = (state == S_IDLE);
    hctrl.start = (state == S_START);
    out_load    = (state == S_WAIT) && hstat.done && out_free;
    hctrl.ack   = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      thr    <= ThrW'(1000000);
      newest <= '0;
      count  <= '0;
      ov     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) thr <= cfg_wdata;
      if (out_load) begin
        ov <= 1'b1;
      end else if (head.ready) begin
        ov <= 1'b0;
      end
      if (state == S_CMP && match) count <= k_inc;
      if (state == S_PUSH) begin
        newest <= newest_next;
        count  <= count_cap + CntW'(1);
      end
    end
  end

  // memory: one registered read, one write
  always_ff @(posedge clk) begin
    rd_data <= mem[slot];
    if (state == S_PUSH) mem[newest_next] <= {f_gz, f_n, f_e};
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        f_e   <= fix.easting_mm;
        f_n   <= fix.northing_mm;
        f_gz  <= {fix.zone_number, fix.zone_band};
        f_tag <= fix.fix_tag;
        k     <= '0;
        slot  <= newest;
      end
      S_DIFF: begin
        de_r <= $signed({1'b0, f_e}) - $signed({1'b0, rd_data[EastW-1:0]});
        dn_r <= $signed({1'b0, f_n}) - $signed({1'b0, rd_data[EastW+NorthW-1:EastW]});
        zm   <= (rd_data[WordW-1:EastW+NorthW] == f_gz);
      end
      S_SQ: begin
        big  <= (ue[30:20] != '0) || (un[34:20] != '0);
        sq_e <= ue[19:0] * ue[19:0];
        sq_n <= un[19:0] * un[19:0];
      end
      S_CMP: begin
        if (!match) begin
          k    <= k_inc;
          slot <= (slot == '0) ? AddrW'(HISTORY_DEPTH - 1) : slot - AddrW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      head.yaw_angle  <= c_yaw;
      head.quat_z     <= c_qz;
      head.quat_w     <= c_qw;
      head.result_tag <= f_tag;
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the GPS track heading estimator
// Drives UTM fixes with random handshake gaps and predicts each heading,
// quaternion term and tag with an in-bench history search and CORDIC model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import gte_pkg::*;

  localparam int Depth      = 1024;
  localparam int SettleCyc  = 4 * Depth + 200;  // worst search plus CORDIC
  localparam int StallLimit = 20000;            // cycles with no request moved
  localparam longint Far    = 64'sd1 << 20;

  localparam longint AtanQ20 [CordicSteps] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct {
    logic [EastW-1:0]  east;
    logic [NorthW-1:0] north;
    logic [5:0]        zone;
    logic [4:0]        band;
    logic [TagW-1:0]   tag;
  } fix_t;

  typedef struct {
    logic signed [OutW-1:0] yaw;
    logic signed [OutW-1:0] qz;
    logic signed [OutW-1:0] qw;
    logic [TagW-1:0]        tag;
  } heading_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ThrW-1:0] cfg_wdata;

  gte_fix_if  fix ();
  gte_head_if head ();

  gps_track_heading_estimator_unit #(.HISTORY_DEPTH(Depth)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fix(fix.sink), .head(head.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the block's history and threshold
  logic [EastW-1:0]  east_hist  [Depth];
  logic [NorthW-1:0] north_hist [Depth];
  logic [ZoneW-1:0]  zone_hist  [Depth];
  int                newest_idx;
  int                hist_len;
  longint            min_dist_sq;

  heading_t pending_headings [$];
  int       fail_count;
  int       shown;
  int       hold_off;   // receiver long hold-off, in cycles
  bit       calm;       // when set neither side idles
  int       stall_left;
  int       quiet_cycles;

  // Heading of displacement (de, dn): vectoring CORDIC for the angle,
  // rotation CORDIC on the half angle for the quaternion terms.
  function automatic heading_t course_of(input longint de, input longint dn);
    heading_t r;
    longint ax, ay, a, mag, h, x, y, xs, ys, s, c, ym;
    ax = de < 0 ? -de : de;
    ay = dn < 0 ? -dn : dn;
    if (ay == 0) begin
      a = 0;
    end else if (ax == 0) begin
      a = longint'(HalfPiQ20);
    end else begin
      while (ax < (64'sd1 << 40) && ay < (64'sd1 << 40)) begin
        ax = ax << 1;
        ay = ay << 1;
      end
      x = ax;
      y = ay;
      a = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; a += AtanQ20[i];
        end else begin
          x -= ys; y += xs; a -= AtanQ20[i];
        end
      end
      if (a < 0) a = 0;
      if (a > longint'(HalfPiQ20)) a = longint'(HalfPiQ20);
    end
    mag = de < 0 ? longint'(PiQ20) - a : a;
    ym = (mag + 64) >>> 7;
    r.yaw = dn < 0 ? -ym : ym;
    h = mag >>> 1;
    x = longint'(GainInvQ30);
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (h >= 0) begin
        x -= ys; y += xs; h -= AtanQ20[i];
      end else begin
        x += ys; y -= xs; h += AtanQ20[i];
      end
    end
    if (y < 0) y = 0;
    if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
    if (x < 0) x = 0;
    if (x > (64'sd1 << 30)) x = 64'sd1 << 30;
    s = (y + (64'sd1 << 15)) >>> 16;
    c = (x + (64'sd1 << 15)) >>> 16;
    r.qz = dn < 0 ? -s : s;
    r.qw = c;
    return r;
  endfunction

  // Search the history for a match, trim it, push the new fix.
  function automatic void track_fix(input fix_t f);
    logic [ZoneW-1:0] gz;
    longint de, dn, ue, un;
    int k, slot;
    bit hit;
    heading_t r;
    gz = {f.zone, f.band};
    hit = 1'b0;
    de = 0;
    dn = 0;
    for (k = 0; k < hist_len; k++) begin
      slot = (newest_idx + Depth - k) % Depth;
      if (zone_hist[slot] != gz) continue;
      de = longint'(f.east) - longint'(east_hist[slot]);
      dn = longint'(f.north) - longint'(north_hist[slot]);
      ue = de < 0 ? -de : de;
      un = dn < 0 ? -dn : dn;
      if (ue >= Far || un >= Far || ue * ue + un * un >= min_dist_sq) begin
        hit = 1'b1;
        break;
      end
    end
    if (hit) begin
      r = course_of(de, dn);
      r.tag = f.tag;
      pending_headings.push_back(r);
      hist_len = k + 1;
    end
    if (hist_len >= Depth) hist_len = Depth - 1;
    newest_idx = (newest_idx + 1) % Depth;
    east_hist[newest_idx]  = f.east;
    north_hist[newest_idx] = f.north;
    zone_hist[newest_idx]  = gz;
    hist_len++;
  endfunction

  // Offer one fix; valid stays high between back-to-back requests and is
  // lowered only when a gap is drawn.
  task automatic send_fix(input fix_t f);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      fix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fix.valid       <= 1'b1;
    fix.easting_mm  <= f.east;
    fix.northing_mm <= f.north;
    fix.zone_number <= f.zone;
    fix.zone_band   <= f.band;
    fix.fix_tag     <= f.tag;
    do @(posedge clk); while (!fix.ready);
    track_fix(f);
  endtask

  task automatic drain();
    fix.valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
    // a fix with no match may still be searching
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [ThrW-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_dist_sq = longint'(v);
  endtask

  function automatic fix_t make_fix(input longint e, input longint n,
                                    input int zone, input int band);
    fix_t f;
    f.east  = e[EastW-1:0];
    f.north = n[NorthW-1:0];
    f.zone  = zone[5:0];
    f.band  = band[4:0];
    f.tag   = $urandom();
    return f;
  endfunction

  // Compass points, field extremes, out-of-range zones and a large offset.
  task automatic test_directed();
    fix_t f;
    send_fix(make_fix(500000000, 5000000000, 31, 10));   // first fix, no match
    send_fix(make_fix(500002000, 5000000000, 31, 10));   // due east
    send_fix(make_fix(500002000, 5000002000, 31, 10));   // due north
    send_fix(make_fix(500000000, 5000002000, 31, 10));   // due west
    send_fix(make_fix(500000000, 5000000000, 31, 10));   // due south
    send_fix(make_fix(500001500, 4999998500, 31, 10));   // south-east
    send_fix(make_fix(500000100, 4999998600, 31, 10));   // west of the last fix, still a match
    send_fix(make_fix(499998000, 5000001000, 31, 10));   // north-west
    send_fix(make_fix(499998000, 5003000000, 31, 10));   // large offset
    send_fix(make_fix(0, 0, 0, 0));                      // zone 0, corner
    send_fix(make_fix((64'sd1 << 30) - 1, (64'sd1 << 34) - 1, 0, 0));
    send_fix(make_fix(0, (64'sd1 << 34) - 1, 63, 31));   // zone and band raw max
    send_fix(make_fix((64'sd1 << 30) - 1, 0, 63, 31));
    send_fix(make_fix(1000, 1000, 1, 0));
    send_fix(make_fix(1000, 1000, 1, 1));                // other band, no match
    send_fix(make_fix(1000, 1000, 2, 0));                // other zone, no match
    send_fix(make_fix(1000 - 3000, 1000, 1, 0));         // wraps to huge easting
    f = make_fix(7777, 7777, 60, 19);
    f.tag = '0;
    send_fix(f);
    f = make_fix(17777, 7777, 60, 19);
    f.tag = '1;
    send_fix(f);
  endtask

  // Zero threshold allows a zero displacement; the top threshold only lets
  // large offsets through.
  task automatic test_threshold_extremes();
    set_threshold('0);
    send_fix(make_fix(300000, 700000, 12, 5));
    send_fix(make_fix(300000, 700000, 12, 5));           // zero displacement
    send_fix(make_fix(299999, 700000, 12, 5));           // one mm west
    send_fix(make_fix(299999, 700001, 12, 5));
    set_threshold('1);
    send_fix(make_fix(300000, 700000, 12, 5));           // far below threshold
    send_fix(make_fix(350000, 750000, 12, 5));
    send_fix(make_fix(350000 + Far, 750000, 12, 5));     // large east offset
    send_fix(make_fix(350000, 750000 - Far, 12, 5));
  endtask

  // Mostly well-formed tracks with random steps, some noise and zone hops.
  task automatic test_random_tracks(input int count);
    longint e, n;
    int zone, band, pick;
    e = $urandom_range(0, (1 << 30) - 1);
    n = {$urandom_range(0, 3), $urandom()};
    zone = $urandom_range(1, 60);
    band = $urandom_range(0, 19);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        e += $signed($urandom_range(0, 8000)) - 4000;
        n += $signed($urandom_range(0, 8000)) - 4000;
      end else if (pick < 78) begin
        e += $signed($urandom_range(0, 600)) - 300;
        n += $signed($urandom_range(0, 600)) - 300;
      end else if (pick < 86) begin
        e += $signed($urandom_range(0, 1 << 23)) - (1 << 22);
        n += $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      end else if (pick < 95) begin
        send_fix(make_fix({$urandom(), $urandom()}, {$urandom(), $urandom()},
                          $urandom_range(0, 63), $urandom_range(0, 31)));
        continue;
      end else begin
        zone = $urandom_range(0, 63);
        band = $urandom_range(0, 31);
      end
      e &= (64'sd1 << 30) - 1;
      n &= (64'sd1 << 34) - 1;
      send_fix(make_fix(e, n, zone, band));
    end
  endtask

  // Hold the result side off while fixes keep coming so the input stalls.
  task automatic test_backpressure();
    hold_off = 400;
    test_random_tracks(30);
  endtask

  task automatic test_no_idling();
    calm = 1'b1;
    test_random_tracks(40);
    calm = 1'b0;
  endtask

  // Check each heading request against the oldest prediction.
  always @(posedge clk) begin
    heading_t want;
    bit next_ready;
    if (rst) begin
      head.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (head.valid && head.ready) begin
        if (pending_headings.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("unexpected heading: tag %h", head.result_tag);
          end
        end else begin
          want = pending_headings.pop_front();
          if (head.yaw_angle !== want.yaw || head.quat_z !== want.qz ||
              head.quat_w !== want.qw || head.result_tag !== want.tag) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("heading mismatch: exp yaw %0d qz %0d qw %0d tag %h",
                       want.yaw, want.qz, want.qw, want.tag);
              $display("                  got yaw %0d qz %0d qw %0d tag %h",
                       head.yaw_angle, head.quat_z, head.quat_w, head.result_tag);
            end
          end
        end
        if (!calm) stall_left = $urandom_range(0, 10);
      end
      if (hold_off > 0) begin
        hold_off--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      head.ready <= next_ready;
    end
  end

  // Watchdog: end the run when no request moves for too long.
  always @(posedge clk) begin
    if (rst || (fix.valid && fix.ready) || (head.valid && head.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    fix.valid       <= 1'b0;
    fix.easting_mm  <= '0;
    fix.northing_mm <= '0;
    fix.zone_number <= '0;
    fix.zone_band   <= '0;
    fix.fix_tag     <= '0;
    fail_count   = 0;
    shown        = 0;
    hold_off     = 0;
    calm         = 1'b0;
    newest_idx   = 0;
    hist_len     = 0;
    min_dist_sq  = 1000000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_threshold_extremes();
    set_threshold(40'd1000000);
    test_random_tracks(110);
    test_backpressure();
    set_threshold(40'd0);
    test_random_tracks(110);
    set_threshold(ThrW'($urandom_range(0, 1 << 24)));
    test_random_tracks(110);
    test_no_idling();
    set_threshold('1);
    test_random_tracks(110);
    drain();

    if (fail_count == 0 && pending_headings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/gte_pkg.sv
design/gte_fix_if.sv
design/gte_head_if.sv
design/gte_heading_cordic.sv
design/gps_track_heading_estimator_unit.sv
tb/tb.sv
